/* design/rne_pkg.sv */
// Shared types, constants and symbol tables for the Roman numeral encoder.
// No dependencies; used by the front, back and top-level modules.
`default_nettype none

package rne_pkg;

  localparam int unsigned ValueW   = 13;
  localparam int unsigned RemW     = 12;
  localparam int unsigned CharW    = 8;
  localparam int unsigned SymIdxW  = 4;
  localparam int unsigned SymCount = 13;
  localparam logic [ValueW-1:0] MaxValid = 13'd3999;
  localparam logic [CharW-1:0]  NoChar   = 8'h00;

  // queue word passed from front to back
  typedef struct packed {
    logic            err;
    logic [RemW-1:0] value;
  } entry_t;

  function automatic logic [RemW-1:0] sym_value(input logic [SymIdxW-1:0] idx);
    logic [RemW-1:0] v;
    case (idx)
      4'd0:    v = 12'd1000;
      4'd1:    v = 12'd900;
      4'd2:    v = 12'd500;
      4'd3:    v = 12'd400;
      4'd4:    v = 12'd100;
      4'd5:    v = 12'd90;
      4'd6:    v = 12'd50;
      4'd7:    v = 12'd40;
      4'd8:    v = 12'd10;
      4'd9:    v = 12'd9;
      4'd10:   v = 12'd5;
      4'd11:   v = 12'd4;
      4'd12:   v = 12'd1;
      default: v = 12'd1;
    endcase
    return v;
  endfunction

  function automatic logic [CharW-1:0] sym_first(input logic [SymIdxW-1:0] idx);
    logic [CharW-1:0] c;
    case (idx)
      4'd0:    c = "M";
      4'd1:    c = "C";
      4'd2:    c = "D";
      4'd3:    c = "C";
      4'd4:    c = "C";
      4'd5:    c = "X";
      4'd6:    c = "L";
      4'd7:    c = "X";
      4'd8:    c = "X";
      4'd9:    c = "I";
      4'd10:   c = "V";
      4'd11:   c = "I";
      4'd12:   c = "I";
      default: c = "I";
    endcase
    return c;
  endfunction

  // NoChar marks a single-letter symbol
  function automatic logic [CharW-1:0] sym_second(input logic [SymIdxW-1:0] idx);
    logic [CharW-1:0] c;
    case (idx)
      4'd1:    c = "M";
      4'd3:    c = "D";
      4'd5:    c = "C";
      4'd7:    c = "L";
      4'd9:    c = "X";
      4'd11:   c = "V";
      default: c = NoChar;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* design/rne_if.sv */
// Valid/ready channel interfaces for the Roman numeral encoder.
// Depends on rne_pkg for field widths.
`default_nettype none

interface rne_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [rne_pkg::ValueW-1:0]   value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rne_out_if;
  logic                        valid;
  logic                        ready;
  logic [rne_pkg::CharW-1:0]   symbol_char;
  logic                        out_of_range;
  logic                        last_char;

  modport source (output valid, output symbol_char, output out_of_range,
                  output last_char, input ready);
  modport sink   (input valid, input symbol_char, input out_of_range,
                  input last_char, output ready);
endinterface

`default_nettype wire

/* design/rne_front.sv */
// Front end: accepts input words, range-checks them and queues them
// in a two-entry FIFO. Depends on rne_pkg and rne_if.
`default_nettype none

module rne_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  rne_in_if.sink              in_ch,
  output rne_pkg::entry_t     q_data,
  output logic                q_valid,
  input  wire logic           q_pop
);

  rne_pkg::entry_t mem_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;
  logic            push;
  logic            pop;
  logic [rne_pkg::ValueW-1:0] raw;
  rne_pkg::entry_t classified;

  // negative values have a 13-bit pattern above MaxValid, so one compare rejects them
  assign raw              = in_ch.value;
  assign classified.err   = (raw == '0) || (raw > rne_pkg::MaxValid);
  assign classified.value = raw[rne_pkg::RemW-1:0];

  assign in_ch.ready = (count_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != 2'd0);
  assign pop         = q_pop && q_valid;
  assign q_data      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= classified;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("front queue count out of range");
`endif

endmodule

`default_nettype wire

/* design/rne_back.sv */
// Back end: pops queued words and emits the numeral one character per cycle
// while the output is not stalled, through an output register. Depends on rne_pkg and rne_if.
`default_nettype none

module rne_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rne_pkg::entry_t q_data,
  input  wire logic           q_valid,
  output logic                q_pop,
  rne_out_if.source           out_ch
);

  logic                          busy_r, busy_nxt;
  logic [rne_pkg::RemW-1:0]      rem_r, rem_nxt;
  logic [rne_pkg::SymIdxW-1:0]   sym_r, sym_nxt;
  logic                          pend_r, pend_nxt;
  logic                          oval_r, oval_nxt;
  logic [rne_pkg::CharW-1:0]     ochar_r, ochar_nxt;
  logic                          oerr_r, oerr_nxt;
  logic                          olast_r, olast_nxt;
  logic                          emit_ok;
  logic [rne_pkg::SymIdxW-1:0]   pick;
  logic [rne_pkg::RemW-1:0]      diff;

  assign emit_ok = !oval_r || out_ch.ready;
  assign q_pop   = q_valid && !busy_r && emit_ok;

  // largest symbol that fits: parallel compares, lowest index wins
  always_comb begin
    pick = rne_pkg::SymIdxW'(rne_pkg::SymCount - 1);
    for (int i = rne_pkg::SymCount - 1; i >= 0; i--) begin
      if (rem_r >= rne_pkg::sym_value(rne_pkg::SymIdxW'(i))) begin
        pick = rne_pkg::SymIdxW'(i);
      end
    end
  end

  assign diff = rem_r - rne_pkg::sym_value(pend_r ? sym_r : pick);

  always_comb begin
    busy_nxt  = busy_r;
    rem_nxt   = rem_r;
    sym_nxt   = sym_r;
    pend_nxt  = pend_r;
    oval_nxt  = oval_r;
    ochar_nxt = ochar_r;
    oerr_nxt  = oerr_r;
    olast_nxt = olast_r;
    if (emit_ok) begin
      oval_nxt = 1'b0;
      if (busy_r) begin
        oval_nxt = 1'b1;
        oerr_nxt = 1'b0;
        if (pend_r) begin
          ochar_nxt = rne_pkg::sym_second(sym_r);
          pend_nxt  = 1'b0;
          rem_nxt   = diff;
          olast_nxt = (diff == '0);
        end else begin
          ochar_nxt = rne_pkg::sym_first(pick);
          sym_nxt   = pick;
          if (rne_pkg::sym_second(pick) != rne_pkg::NoChar) begin
            pend_nxt  = 1'b1;
            olast_nxt = 1'b0;
          end else begin
            rem_nxt   = diff;
            olast_nxt = (diff == '0);
          end
        end
        if (olast_nxt) begin
          busy_nxt = 1'b0;
        end
      end else if (q_pop) begin
        if (q_data.err) begin
          oval_nxt  = 1'b1;
          ochar_nxt = rne_pkg::NoChar;
          oerr_nxt  = 1'b1;
          olast_nxt = 1'b1;
        end else begin
          busy_nxt = 1'b1;
          rem_nxt  = q_data.value;
          pend_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= pend_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    sym_r   <= sym_nxt;
    ochar_r <= ochar_nxt;
    oerr_r  <= oerr_nxt;
    olast_r <= olast_nxt;
  end

  assign out_ch.valid        = oval_r;
  assign out_ch.symbol_char  = ochar_r;
  assign out_ch.out_of_range = oerr_r;
  assign out_ch.last_char    = olast_r;

`ifndef SYNTHESIS
  a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> busy_r)
    else $error("second letter pending while idle");

  a_busy_rem: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r != '0))
    else $error("engine busy with nothing left");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (oval_r && oerr_r) |-> (olast_r && (ochar_r == rne_pkg::NoChar)))
    else $error("error word not a single last word");

  a_pend_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && emit_ok) |=> !pend_r)
    else $error("second letter not emitted");
`endif

endmodule

`default_nettype wire

/* design/roman_numeral_encoder_unit.sv */
// Roman numeral encoder top level: in-range value of n characters occupies the
// back-end sequencer for a load step, then one character per cycle while the
// output is not stalled; an out-of-range value gives a single error word. An
// accepted in-range word is queued, loaded by the sequencer, then emitted via the
// output register. A two-word queue decouples input acceptance from emission.
// Reset: synchronous active-low rst_n clears queue and sequencer control.
`default_nettype none

module roman_numeral_encoder_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rne_in_if.sink      in_ch,
  rne_out_if.source   out_ch
);

  rne_pkg::entry_t q_data;
  logic            q_valid;
  logic            q_pop;

  rne_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  rne_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
